// ===== hw/rtl/shift_register_input_scanner_macros.svh =====
// Assertion macros for the shift register input scanner.
// Included by files that check their own logic; needs clk and arst_n in scope.
`ifndef SHIFT_REGISTER_INPUT_SCANNER_MACROS_SVH
`define SHIFT_REGISTER_INPUT_SCANNER_MACROS_SVH

// Same-cycle implication, checked outside reset
`define SRIS_ASSERT_IMPLY(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sris check failed");

// Next-cycle implication, checked outside reset
`define SRIS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sris check failed");

`endif

// ===== hw/rtl/sris_pkg.sv =====
// Shared types and constants for the shift register input scanner.
// No dependencies; used by the core, the output buffer and the top level.
package sris_pkg;

	localparam int MAX_CHIPS = 8;
	localparam int MAP_W     = 24;
	localparam int CFG_IDX_W = 4;
	localparam int POS_W     = 4;
	localparam int CNT_W     = 3;

	// identity remap: field k holds k
	localparam logic [MAP_W-1:0] MAP_RESET = 24'hFAC688;

	typedef enum logic [1:0] {
		ACT_START = 2'd0,
		ACT_SHIFT = 2'd1,
		ACT_CLEAR = 2'd2,
		ACT_QUERY = 2'd3
	} action_t;

	typedef logic [MAP_W-1:0] map_t;

	typedef struct packed {
		logic       load_pulse;
		logic       shift_clock;
		logic       byte_done;
		logic [2:0] byte_chip;
		logic [7:0] byte_value;
		logic       scan_done;
		logic       bit_value;
	} result_t;

endpackage

// ===== hw/rtl/sris_core.sv =====
// Scan state and per-request result logic of the shift register input scanner.
// Depends on sris_pkg.
module sris_core #(
	parameter int CHIPS = 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   take,
	input  sris_pkg::action_t      action,
	input  logic                   serial_in,
	input  logic [5:0]             bit_index,
	input  sris_pkg::map_t         maps [sris_pkg::MAX_CHIPS],
	output sris_pkg::result_t      result
);

	logic [7:0]                     stored_q [sris_pkg::MAX_CHIPS];
	logic [7:0]                     acc_q;
	logic [sris_pkg::CNT_W-1:0]     cnt_q;
	logic [sris_pkg::POS_W-1:0]     pos_q;

	logic                           active;
	logic [2:0]                     chip;
	logic [4:0]                     tgt_lsb;
	logic [2:0]                     tgt;
	logic [7:0]                     acc_or;
	logic [7:0]                     byte_inv;
	logic [sris_pkg::POS_W-1:0]     pos_inc;
	logic                           last_bit;
	logic                           in_chain;

	// datapath for one shifted bit
	assign active   = pos_q < sris_pkg::POS_W'(CHIPS);
	assign chip     = pos_q[2:0];
	assign tgt_lsb  = 5'(cnt_q) * 5'd3;
	assign tgt      = maps[chip][tgt_lsb +: 3];
	assign acc_or   = acc_q | (8'(serial_in) << tgt);
	assign byte_inv = ~acc_or;
	assign pos_inc  = pos_q + sris_pkg::POS_W'(1);
	assign last_bit = cnt_q == sris_pkg::CNT_W'(7);
	assign in_chain = {1'b0, bit_index} < 7'(CHIPS * 8);

	// result of the current request; unused fields stay zero
	always_comb begin
		result = '0;
		case (action)
			sris_pkg::ACT_START: begin
				result.load_pulse = 1'b1;
			end
			sris_pkg::ACT_SHIFT: begin
				if (active) begin
					result.shift_clock = 1'b1;
					if (last_bit) begin
						result.byte_done  = 1'b1;
						result.byte_chip  = chip;
						result.byte_value = byte_inv;
						result.scan_done  = pos_inc >= sris_pkg::POS_W'(CHIPS);
					end
				end
			end
			sris_pkg::ACT_CLEAR: begin
				result = '0;
			end
			sris_pkg::ACT_QUERY: begin
				if (in_chain)
					result.bit_value = stored_q[bit_index[5:3]][bit_index[2:0]];
			end
			default: begin
				result = '0;
			end
		endcase
	end

	// scan state update on each accepted request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < sris_pkg::MAX_CHIPS; i++)
				stored_q[i] <= '0;
			acc_q <= '0;
			cnt_q <= '0;
			pos_q <= sris_pkg::POS_W'(CHIPS);
		end else if (take) begin
			case (action)
				sris_pkg::ACT_START: begin
					pos_q <= '0;
					cnt_q <= '0;
					acc_q <= '0;
				end
				sris_pkg::ACT_SHIFT: begin
					if (active) begin
						if (last_bit) begin
							stored_q[chip] <= byte_inv;
							pos_q          <= pos_inc;
							cnt_q          <= '0;
							acc_q          <= '0;
						end else begin
							cnt_q <= cnt_q + sris_pkg::CNT_W'(1);
							acc_q <= acc_or;
						end
					end
				end
				sris_pkg::ACT_CLEAR: begin
					for (int i = 0; i < sris_pkg::MAX_CHIPS; i++)
						stored_q[i] <= '0;
				end
				default: begin
					// query leaves the state alone
				end
			endcase
		end
	end

endmodule

// ===== hw/rtl/sris_skid.sv =====
// Two-entry output buffer (result register plus skid slot) for scanner results.
// Depends on sris_pkg.
module sris_skid (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  sris_pkg::result_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output sris_pkg::result_t  out_data
);

	logic               out_v_q;
	logic               skid_v_q;
	sris_pkg::result_t  out_d_q;
	sris_pkg::result_t  skid_d_q;
	logic               push;
	logic               pop;
	logic               out_free;

	assign in_ready  = !skid_v_q;
	assign push      = in_valid && in_ready;
	assign pop       = out_v_q && out_ready;
	assign out_free  = !out_v_q || pop;
	assign out_valid = out_v_q;
	assign out_data  = out_d_q;

	// occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (out_free) begin
			out_v_q  <= skid_v_q || push;
			skid_v_q <= 1'b0;
		end else if (push) begin
			skid_v_q <= 1'b1;
		end
	end

	// payload: skid drains first, new request lands where there is room
	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_v_q)
				out_d_q <= skid_d_q;
			else if (push)
				out_d_q <= in_data;
		end else if (push) begin
			skid_d_q <= in_data;
		end
	end

endmodule

// ===== hw/rtl/shift_register_input_scanner.sv =====
// Shift register input scanner: takes one request per clock, including back to back, and
// presents its result from a registered buffer. A request is taken even while an earlier
// result waits downstream; a two-entry output buffer (result register plus skid slot)
// sets the limit, so s_tready drops only once two results are held. The user writes remap
// registers via cfg_we/cfg_index/cfg_data only when no request is in flight; not enforced.
// Depends on sris_pkg, sris_core, sris_skid and shift_register_input_scanner_macros.svh.
`include "shift_register_input_scanner_macros.svh"

module shift_register_input_scanner #(
	parameter int CHIPS = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// request stream
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [7:0]                    s_tdata,  // serial_in[0], bit_index[6:1], zero[7]
	input  logic [1:0]                    s_tuser,  // action[1:0]
	// result stream
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// load_pulse[0], shift_clock[1], byte_done[2], byte_chip[5:3],
	// byte_value[13:6], scan_done[14], bit_value[15]
	output logic [15:0]                   m_tdata,
	// remap register writes
	input  logic                          cfg_we,
	input  logic [sris_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [sris_pkg::MAP_W-1:0]    cfg_data
);

	sris_pkg::map_t     maps_q [sris_pkg::MAX_CHIPS];
	sris_pkg::result_t  core_res;
	sris_pkg::result_t  out_res;
	logic               take;

	// remap registers; indexes past the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < sris_pkg::MAX_CHIPS; i++)
				maps_q[i] <= sris_pkg::MAP_RESET;
		end else if (cfg_we && cfg_index < sris_pkg::CFG_IDX_W'(sris_pkg::MAX_CHIPS)) begin
			maps_q[cfg_index[2:0]] <= cfg_data;
		end
	end

	assign take = s_tvalid && s_tready;

	sris_core #(
		.CHIPS(CHIPS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.action    (sris_pkg::action_t'(s_tuser)),
		.serial_in (s_tdata[0]),
		.bit_index (s_tdata[6:1]),
		.maps      (maps_q),
		.result    (core_res)
	);

	sris_skid u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_data   (core_res),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (out_res)
	);

	// result packing
	assign m_tdata = {out_res.bit_value, out_res.scan_done, out_res.byte_value,
		out_res.byte_chip, out_res.byte_done, out_res.shift_clock, out_res.load_pulse};

	// checks
	`SRIS_ASSERT_IMPLY(a_scan_needs_byte, m_tvalid && out_res.scan_done, out_res.byte_done)
	`SRIS_ASSERT_IMPLY(a_byte_needs_clock, m_tvalid && out_res.byte_done, out_res.shift_clock)
	`SRIS_ASSERT_IMPLY(a_one_kind, m_tvalid,
		$onehot0({out_res.load_pulse, out_res.shift_clock, out_res.bit_value}))
	`SRIS_ASSERT_NEXT(a_take_gives_result, take, m_tvalid)

endmodule

// ===== tb/tb_top.sv =====
// Self-checking bench for shift_register_input_scanner: random-gap driver, stalling monitor,
// and an in-bench scan predictor that tracks stored bytes, accumulator and remap registers.
// Depends on sris_pkg and the scanner RTL only.
`timescale 1ns / 100ps

module tb_top;

	localparam int NCHIPS = 8;

	typedef struct packed {
		sris_pkg::action_t act;
		logic              sin;
		logic [5:0]        idx;
	} scan_req_t;

	logic        clk;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata   = '0;  // serial_in[0], bit_index[6:1], zero[7]
	logic [1:0]  s_tuser   = '0;  // action[1:0]
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	// load_pulse[0], shift_clock[1], byte_done[2], byte_chip[5:3],
	// byte_value[13:6], scan_done[14], bit_value[15]
	logic [15:0] m_tdata;
	logic        cfg_we    = 1'b0;
	logic [sris_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	sris_pkg::map_t cfg_data = '0;
	logic        hold_off  = 1'b0;

	shift_register_input_scanner #(.CHIPS(NCHIPS)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	// predictor state
	sris_pkg::map_t chip_map [8];
	logic [7:0]  saved_bytes [8];
	logic [7:0]  accum;
	logic [2:0]  shift_cnt;
	logic [3:0]  chip_pos;

	scan_req_t          request_q[$];
	sris_pkg::result_t  pending_results[$];

	int accepted_cnt = 0;
	int checked_cnt  = 0;
	int error_cnt    = 0;
	int bytes_seen   = 0;
	int scans_seen   = 0;
	int settings_cnt = 0;
	bit quiet_phase  = 1'b0;

	// clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// run limit
	initial begin
		#20ms;
		$display("timeout: %0d requests accepted, %0d results pending",
			accepted_cnt, pending_results.size());
		$display("*** FAILED ***");
		$finish;
	end

	// mostly short gaps, a few long ones; none in quiet phases
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (quiet_phase || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// expected result of one request; advances the scan state
	function automatic sris_pkg::result_t scan_predict(scan_req_t r);
		sris_pkg::result_t res;
		logic [2:0] tgt;
		logic [7:0] v;
		res = '0;
		case (r.act)
			sris_pkg::ACT_START: begin
				res.load_pulse = 1'b1;
				chip_pos  = '0;
				shift_cnt = '0;
				accum     = '0;
			end
			sris_pkg::ACT_SHIFT: begin
				// ignored once the chain is done or before any start
				if (chip_pos < NCHIPS) begin
					tgt = chip_map[chip_pos[2:0]][int'(shift_cnt) * 3 +: 3];
					if (r.sin)
						accum[tgt] = 1'b1;
					res.shift_clock = 1'b1;
					if (shift_cnt == 3'd7) begin
						v = ~accum;
						saved_bytes[chip_pos[2:0]] = v;
						res.byte_done  = 1'b1;
						res.byte_chip  = chip_pos[2:0];
						res.byte_value = v;
						chip_pos = chip_pos + 4'd1;
						if (chip_pos >= NCHIPS)
							res.scan_done = 1'b1;
						shift_cnt = '0;
						accum     = '0;
					end else begin
						shift_cnt = shift_cnt + 3'd1;
					end
				end
			end
			sris_pkg::ACT_CLEAR: begin
				for (int i = 0; i < 8; i++)
					saved_bytes[i] = '0;
			end
			default: begin
				if (r.idx < NCHIPS * 8)
					res.bit_value = saved_bytes[r.idx[5:3]][r.idx[2:0]];
			end
		endcase
		return res;
	endfunction

	// driver: one request per handshake, gaps between
	scan_req_t drv_cur;
	int        drv_gap = 0;
	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				pending_results.push_back(scan_predict(drv_cur));
				accepted_cnt++;
			end
			if (!s_tvalid || s_tready) begin
				if (drv_gap > 0) begin
					drv_gap--;
					s_tvalid <= 1'b0;
				end else if (request_q.size() > 0) begin
					drv_cur = request_q.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= {1'b0, drv_cur.idx, drv_cur.sin};
					s_tuser  <= drv_cur.act;
					drv_gap = pick_gap();
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// monitor: random ready, compare against oldest expectation
	int                mon_gap = 0;
	sris_pkg::result_t got;
	sris_pkg::result_t want;
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			got.load_pulse  = m_tdata[0];
			got.shift_clock = m_tdata[1];
			got.byte_done   = m_tdata[2];
			got.byte_chip   = m_tdata[5:3];
			got.byte_value  = m_tdata[13:6];
			got.scan_done   = m_tdata[14];
			got.bit_value   = m_tdata[15];
			if (pending_results.size() == 0) begin
				error_cnt++;
				if (error_cnt <= 10)
					$display("unexpected result %h with nothing pending", m_tdata);
			end else begin
				want = pending_results.pop_front();
				checked_cnt++;
				if (want.byte_done === 1'b1)
					bytes_seen++;
				if (want.scan_done === 1'b1)
					scans_seen++;
				if (got.load_pulse !== want.load_pulse || got.shift_clock !== want.shift_clock ||
				    got.byte_done !== want.byte_done || got.byte_chip !== want.byte_chip ||
				    got.byte_value !== want.byte_value || got.scan_done !== want.scan_done ||
				    got.bit_value !== want.bit_value) begin
					error_cnt++;
					if (error_cnt <= 10)
						$display({"mismatch at result %0d: exp load=%b clk=%b done=%b chip=%0d ",
							"val=%h scan=%b bit=%b / got load=%b clk=%b done=%b chip=%0d ",
							"val=%h scan=%b bit=%b"}, checked_cnt,
							want.load_pulse, want.shift_clock, want.byte_done, want.byte_chip,
							want.byte_value, want.scan_done, want.bit_value,
							got.load_pulse, got.shift_clock, got.byte_done, got.byte_chip,
							got.byte_value, got.scan_done, got.bit_value);
				end
			end
		end
		if (hold_off) begin
			m_tready <= 1'b0;
		end else if (mon_gap > 0) begin
			mon_gap--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
			mon_gap = pick_gap();
		end
	end

	// long receiver hold-off while the sender keeps offering
	initial begin
		do @(negedge clk); while (accepted_cnt < 300);
		@(posedge clk);
		hold_off <= 1'b1;
		repeat (400) @(posedge clk);
		hold_off <= 1'b0;
	end

	task automatic add_req(input sris_pkg::action_t a, input logic sin, input logic [5:0] idx);
		scan_req_t r;
		r.act = a;
		r.sin = sin;
		r.idx = idx;
		request_q.push_back(r);
	endtask

	task automatic wait_idle();
		do @(negedge clk); while (request_q.size() > 0 || s_tvalid || pending_results.size() > 0);
		repeat (4) @(negedge clk);
	endtask

	// one map setting: all eight chip maps plus the ignored indices above them
	task automatic write_maps(input int kind);
		sris_pkg::map_t v;
		for (int i = 0; i < 16; i++) begin
			v = '0;
			case (kind)
				0: v = sris_pkg::MAP_RESET;
				1: v = '0;
				2: v = '1;
				3: for (int k = 0; k < 8; k++) v[k * 3 +: 3] = 3'(7 - k);
				default: v = sris_pkg::map_t'($urandom);
			endcase
			if (i >= 8)
				v = sris_pkg::map_t'($urandom);
			@(posedge clk);
			cfg_we    <= 1'b1;
			cfg_index <= sris_pkg::CFG_IDX_W'(i);
			cfg_data  <= v;
			if (i < 8)
				chip_map[i] = v;
		end
		@(posedge clk);
		cfg_we <= 1'b0;
		settings_cnt++;
	endtask

	// random traffic, mostly well-formed scans with random serial data
	task automatic gen_random(input int budget);
		int added;
		int r;
		int n;
		added = 0;
		while (added < budget) begin
			r = $urandom_range(0, 99);
			if (r < 55) begin
				add_req(sris_pkg::ACT_START, 1'($urandom), 6'($urandom));
				added++;
				for (int i = 0; i < NCHIPS * 8; i++) begin
					if ($urandom_range(0, 39) == 0) begin
						add_req($urandom_range(0, 1) ? sris_pkg::ACT_CLEAR : sris_pkg::ACT_QUERY,
							1'($urandom), 6'($urandom));
						added++;
					end
					add_req(sris_pkg::ACT_SHIFT, 1'($urandom), 6'($urandom));
					added++;
				end
				n = $urandom_range(1, 4);
				for (int i = 0; i < n; i++)
					add_req(sris_pkg::ACT_QUERY, 1'($urandom), 6'($urandom));
				added += n;
			end else if (r < 70) begin
				// partial scan, sometimes restarted
				add_req(sris_pkg::ACT_START, 1'($urandom), 6'($urandom));
				n = $urandom_range(1, 40);
				for (int i = 0; i < n; i++)
					add_req(sris_pkg::ACT_SHIFT, 1'($urandom), 6'($urandom));
				added += n + 1;
			end else if (r < 85) begin
				if ($urandom_range(0, 3) == 0) begin
					add_req(sris_pkg::ACT_CLEAR, 1'($urandom), 6'($urandom));
					added++;
				end
				n = $urandom_range(4, 12);
				for (int i = 0; i < n; i++)
					add_req(sris_pkg::ACT_QUERY, 1'($urandom), 6'($urandom));
				added += n;
			end else begin
				// noise; shifts in it do not count
				n = $urandom_range(1, 6);
				for (int i = 0; i < n; i++) begin
					add_req(sris_pkg::action_t'($urandom_range(0, 3)), 1'($urandom),
						6'($urandom));
					if (request_q[$].act != sris_pkg::ACT_SHIFT)
						added++;
				end
			end
		end
	endtask

	// main sequence
	initial begin
		for (int i = 0; i < 8; i++) begin
			chip_map[i]    = sris_pkg::MAP_RESET;
			saved_bytes[i] = '0;
		end
		accum     = '0;
		shift_cnt = '0;
		chip_pos  = 4'(NCHIPS);

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// directed: reset maps, idle shift, one byte, restart and clear mid-scan
		@(negedge clk);
		add_req(sris_pkg::ACT_QUERY, 1'b0, 6'd0);
		add_req(sris_pkg::ACT_QUERY, 1'b1, 6'd63);
		add_req(sris_pkg::ACT_SHIFT, 1'b1, 6'd0);
		add_req(sris_pkg::ACT_CLEAR, 1'b0, 6'd63);
		add_req(sris_pkg::ACT_START, 1'b1, 6'd63);
		add_req(sris_pkg::ACT_SHIFT, 1'b1, 6'd63);
		add_req(sris_pkg::ACT_SHIFT, 1'b0, 6'd0);
		add_req(sris_pkg::ACT_SHIFT, 1'b1, 6'd0);
		add_req(sris_pkg::ACT_SHIFT, 1'b1, 6'd0);
		add_req(sris_pkg::ACT_SHIFT, 1'b0, 6'd0);
		add_req(sris_pkg::ACT_SHIFT, 1'b0, 6'd0);
		add_req(sris_pkg::ACT_SHIFT, 1'b1, 6'd0);
		add_req(sris_pkg::ACT_SHIFT, 1'b0, 6'd0);
		add_req(sris_pkg::ACT_QUERY, 1'b0, 6'd1);
		add_req(sris_pkg::ACT_QUERY, 1'b0, 6'd7);
		add_req(sris_pkg::ACT_START, 1'b0, 6'd0);
		add_req(sris_pkg::ACT_SHIFT, 1'b1, 6'd0);
		add_req(sris_pkg::ACT_SHIFT, 1'b1, 6'd0);
		add_req(sris_pkg::ACT_START, 1'b0, 6'd0);
		add_req(sris_pkg::ACT_SHIFT, 1'b0, 6'd0);
		add_req(sris_pkg::ACT_CLEAR, 1'b1, 6'd0);
		add_req(sris_pkg::ACT_QUERY, 1'b0, 6'd2);
		add_req(sris_pkg::ACT_SHIFT, 1'b1, 6'd0);
		add_req(sris_pkg::ACT_QUERY, 1'b1, 6'd40);
		wait_idle();

		// random phases over several map settings, extremes included
		for (int kind = 0; kind < 6; kind++) begin
			write_maps(kind);
			@(negedge clk);
			quiet_phase = (kind == 3);
			gen_random(200);
			wait_idle();
		end

		repeat (20) @(negedge clk);
		$display("covered %0d requests over %0d map settings: %0d results checked,",
			accepted_cnt, settings_cnt, checked_cnt);
		$display("  %0d chip bytes completed, %0d full chain scans, %0d errors",
			bytes_seen, scans_seen, error_cnt);
		if (error_cnt == 0 && pending_results.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
